@@ design/tick_burst_bin_counter_defines.svh @@
// Assertion macros for the checker file.
`ifndef TICK_BURST_BIN_COUNTER_DEFINES_SVH
`define TICK_BURST_BIN_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TBBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TBBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/tbbc_pkg.sv @@
package tbbc_pkg;

  localparam int NUM_BINS = 16;
  localparam int IDX_W    = $clog2(NUM_BINS);
  localparam int CNT_W    = $clog2(NUM_BINS + 2) + 1;
  localparam int PADDR_W  = 3;

  localparam logic [31:0] GAP_NEAR_MS = 32'd2000;
  localparam logic [31:0] MS_PER_S    = 32'd1000;
  localparam logic [31:0] OVERLAP_GAP = 32'd65535;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [CNT_W-1:0] BINS_C = CNT_W'(NUM_BINS);

  typedef enum logic [0:0] {
    REG_ALONE_AGE = 1'b0,
    REG_MIN_TICKS = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAN,
    ST_INSERT,
    ST_SCAN,
    ST_MERGE_A,
    ST_MERGE_B,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] start_ms;
    logic [31:0] length_ms;
    logic [15:0] ticks;
  } bin_t;

  function automatic logic [31:0] bin_end(input bin_t b);
    return b.start_ms + b.length_ms;
  endfunction

  // Gap from the end of bin a to the start of bin b.
  function automatic logic [31:0] gap_f(input bin_t a, input bin_t b);
    logic [31:0] ea;
    ea = bin_end(a);
    if (a.ticks == '0 || b.ticks == '0) return '0;
    if (b.start_ms < ea) return OVERLAP_GAP;
    return b.start_ms - ea;
  endfunction

endpackage

@@ design/tbbc_in_if.sv @@
interface tbbc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] now_ms;

  modport source (output valid, output action, output now_ms, input ready);
  modport sink (input valid, input action, input now_ms, output ready);
endinterface

@@ design/tbbc_out_if.sv @@
interface tbbc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_ticks;
  logic [6:0]  bins_used;
  logic [31:0] last_tick_ms;
  logic [31:0] idle_ms;
  logic        is_empty;

  modport source (output valid, output total_ticks, output bins_used, output last_tick_ms,
                  output idle_ms, output is_empty, input ready);
  modport sink (input valid, input total_ticks, input bins_used, input last_tick_ms,
                input idle_ms, input is_empty, output ready);
endinterface

@@ design/tick_burst_bin_counter.sv @@
// Sequence: a report item makes one cleaning pass over the bins in use and then loads the
// result. A tick item cleans, inserts the new tick when a bin is free, cleans, scans for
// the closest pair, merges that pair with two writes when needed, cleans again and loads
// the result. Each pass reads every entry from memory in turn, plus one read past the last.
// The result register lets the next item start while a result waits.
// Reset: asynchronous, active low; row empty (fill count 0), registers 60 s and 3 ticks.
module tick_burst_bin_counter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tbbc_in_if.sink                      in_i,
  tbbc_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tbbc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tbbc_pkg::*;

  // bins live in one memory; entries at or past the fill count read as empty
  bin_t mem_q [NUM_BINS];
  bin_t rd_q;
  logic rd_ok_q, rd_ok_d;

  logic           we;
  logic [IDX_W-1:0] wa;
  bin_t           wd;

  state_e state_q, state_d;
  logic [1:0]       pass_q, pass_d;
  logic             act_q, act_d;
  logic [31:0]      now_q, now_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] ra_q, ra_d;
  logic             dv_q, dv_d;
  logic [CNT_W-1:0] dj_q, dj_d;
  bin_t             cur_q, cur_d;
  bin_t             prev_q, prev_d;
  logic             prev_none_q, prev_none_d;
  logic [CNT_W-1:0] w_q, w_d;
  logic [31:0]      total_q, total_d;
  logic [31:0]      last_q, last_d;
  logic [31:0]      best_q, best_d;
  logic [IDX_W-1:0] at_q, at_d;
  bin_t             ea_q, ea_d;
  bin_t             eb_q, eb_d;
  logic [15:0]      age_cfg_q, min_cfg_q;

  logic        out_valid_q;
  logic [31:0] out_total_q, out_last_q, out_idle_q;
  logic [6:0]  out_used_q;
  logic        out_empty_q;
  logic        load_out;

  bin_t        d;
  logic [31:0] max_age, cur_end, age, dprev, dnext, g;
  logic        noise, keep;
  logic [16:0] sum;

  // APB configuration
  assign pready = 1'b1;
  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_ALONE_AGE: prdata = {16'b0, age_cfg_q};
      REG_MIN_TICKS: prdata = {16'b0, min_cfg_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_cfg_q <= 16'd60;
      min_cfg_q <= 16'd3;
    end else if (psel && penable && pwrite) begin
      if (reg_idx_e'(paddr[2]) == REG_ALONE_AGE) age_cfg_q <= pwdata[15:0];
      else min_cfg_q <= pwdata[15:0];
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra_q[IDX_W-1:0]];
  end

  // datapath for the denoise test and the gap scan
  assign d       = rd_ok_q ? rd_q : '0;
  assign max_age = {16'b0, age_cfg_q} * MS_PER_S;
  assign cur_end = bin_end(cur_q);
  assign age     = (now_q >= cur_end) ? now_q - cur_end : '0;
  assign dprev   = prev_none_q ? max_age : gap_f(prev_q, cur_q);
  assign dnext   = (d.ticks != '0) ? gap_f(cur_q, d) : max_age;
  assign noise   = (cur_q.ticks != '0) && (age > max_age) && (cur_q.ticks < min_cfg_q) &&
                   (dprev >= GAP_NEAR_MS) && (dnext >= GAP_NEAR_MS);
  assign keep    = (cur_q.ticks != '0) && !noise;
  assign g       = gap_f(cur_q, d);
  assign sum     = {1'b0, ea_q.ticks} + {1'b0, eb_q.ticks};

  assign in_i.ready = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    act_d       = act_q;
    now_d       = now_q;
    n_d         = n_q;
    ra_d        = ra_q;
    dv_d        = 1'b0;
    dj_d        = ra_q;
    rd_ok_d     = 1'b0;
    cur_d       = cur_q;
    prev_d      = prev_q;
    prev_none_d = prev_none_q;
    w_d         = w_q;
    total_d     = total_q;
    last_d      = last_q;
    best_d      = best_q;
    at_d        = at_q;
    ea_d        = ea_q;
    eb_d        = eb_q;
    we          = 1'b0;
    wa          = '0;
    wd          = '0;
    load_out    = 1'b0;

    // stream reads of entries 0..n
    if ((state_q == ST_CLEAN || state_q == ST_SCAN) && ra_q <= n_q) begin
      ra_d    = ra_q + 1'b1;
      dv_d    = 1'b1;
      rd_ok_d = (ra_q < n_q);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          act_d   = in_i.action;
          now_d   = in_i.now_ms;
          pass_d  = 2'd0;
          state_d = ST_CLEAN;
          ra_d = '0; w_d = '0; total_d = '0; last_d = '0;
        end
      end
      ST_CLEAN: begin
        if (dv_q) begin
          if (dj_q == '0) begin
            prev_none_d = 1'b1;
          end else begin
            prev_none_d = 1'b0;
            prev_d      = noise ? '0 : cur_q;
            if (keep) begin
              we      = 1'b1;
              wa      = w_q[IDX_W-1:0];
              wd      = cur_q;
              w_d     = w_q + 1'b1;
              total_d = total_q + {16'b0, cur_q.ticks};
              last_d  = cur_end;
            end
          end
          cur_d = d;
          if (dj_q == n_q) begin
            n_d  = w_d;
            ra_d = '0;
            dv_d = 1'b0;
            if (act_q || pass_q == 2'd2) state_d = ST_DONE;
            else if (pass_q == 2'd0) state_d = ST_INSERT;
            else state_d = ST_SCAN;
          end
        end
      end
      ST_INSERT: begin
        if (n_q < BINS_C) begin
          we  = 1'b1;
          wa  = n_q[IDX_W-1:0];
          wd  = '{start_ms: now_q, length_ms: '0, ticks: 16'd1};
          n_d = n_q + 1'b1;
        end
        pass_d  = 2'd1;
        state_d = ST_CLEAN;
        ra_d = '0; w_d = '0; total_d = '0; last_d = '0;
      end
      ST_SCAN: begin
        if (dv_q) begin
          cur_d = d;
          if (dj_q != '0 && dj_q < n_q) begin
            if (dj_q == CNT_W'(1) || g < best_q) begin
              best_d = g;
              at_d   = IDX_W'(dj_q - 1'b1);
              ea_d   = cur_q;
              eb_d   = d;
            end
          end
          if (dj_q == n_q) begin
            pass_d = 2'd2;
            ra_d   = '0;
            dv_d   = 1'b0;
            if (n_q >= CNT_W'(2) && (n_q == BINS_C || best_q == '0)) begin
              state_d = ST_MERGE_A;
            end else begin
              state_d = ST_CLEAN;
              w_d = '0; total_d = '0; last_d = '0;
            end
          end
        end
      end
      ST_MERGE_A: begin
        we           = 1'b1;
        wa           = at_q;
        wd.start_ms  = ea_q.start_ms;
        wd.length_ms = bin_end(eb_q) - ea_q.start_ms;
        wd.ticks     = sum[16] ? COUNT_MAX : sum[15:0];
        state_d      = ST_MERGE_B;
      end
      ST_MERGE_B: begin
        we      = 1'b1;
        wa      = at_q + 1'b1;
        wd      = '0;
        state_d = ST_CLEAN;
        ra_d = '0; w_d = '0; total_d = '0; last_d = '0;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= '0;
      n_q     <= '0;
      ra_q    <= '0;
      dv_q    <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      n_q     <= n_d;
      ra_q    <= ra_d;
      dv_q    <= dv_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    now_q       <= now_d;
    dj_q        <= dj_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    prev_none_q <= prev_none_d;
    w_q         <= w_d;
    total_q     <= total_d;
    last_q      <= last_d;
    best_q      <= best_d;
    at_q        <= at_d;
    ea_q        <= ea_d;
    eb_q        <= eb_d;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (load_out) out_valid_q <= 1'b1;
    else if (out_o.ready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_total_q <= total_q;
      out_used_q  <= 7'(n_q);
      out_last_q  <= last_q;
      out_empty_q <= (n_q == '0);
      if (n_q == '0) out_idle_q <= '1;
      else out_idle_q <= (now_q >= last_q) ? now_q - last_q : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.total_ticks  = out_total_q;
  assign out_o.bins_used    = out_used_q;
  assign out_o.last_tick_ms = out_last_q;
  assign out_o.idle_ms      = out_idle_q;
  assign out_o.is_empty     = out_empty_q;

endmodule

@@ design/tbbc_checker.sv @@
`include "tick_burst_bin_counter_defines.svh"

module tbbc_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] total_ticks,
  input logic [6:0]  bins_used,
  input logic [31:0] last_tick_ms,
  input logic [31:0] idle_ms,
  input logic        is_empty
);
  import tbbc_pkg::*;

  // a stalled result stays valid and keeps its tick total
  `TBBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(total_ticks), "result changed while stalled")

  // empty flag agrees with the bin count, which stays within NUM_BINS
  `TBBC_ASSERT_NOW(a_empty_cnt, out_valid, is_empty == (bins_used == 7'd0) && bins_used <= 7'(NUM_BINS), "empty flag and bin count disagree")

  // an empty row reports no ticks, no last time and an all-ones idle time
  `TBBC_ASSERT_NOW(a_empty_vals, out_valid && is_empty, total_ticks == '0 && last_tick_ms == '0 && idle_ms == '1, "empty row reports stale values")

  // every used bin holds at least one tick
  `TBBC_ASSERT_NOW(a_ticks_min, out_valid && !is_empty, total_ticks >= {25'b0, bins_used}, "fewer ticks than bins in use")

endmodule

bind tick_burst_bin_counter tbbc_sva u_tbbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .total_ticks  (out_o.total_ticks),
  .bins_used    (out_o.bins_used),
  .last_tick_ms (out_o.last_tick_ms),
  .idle_ms      (out_o.idle_ms),
  .is_empty     (out_o.is_empty)
);
